[rtl/stt_pkg.sv]
// Shared types, codes and byte classification for the source text tokenizer.
package stt_pkg;

    localparam int DEF_MAX_TEXT_BYTES = 1048576;
    localparam int FQ_DEPTH = 4;
    localparam int OQ_DEPTH = 4;

    localparam logic [5:0] KIND_EOF      = 6'd0;
    localparam logic [5:0] KIND_NEWLINE  = 6'd1;
    localparam logic [5:0] KIND_BLOCK    = 6'd2;
    localparam logic [5:0] KIND_LINE     = 6'd3;
    localparam logic [5:0] KIND_IDENT    = 6'd4;
    localparam logic [5:0] KIND_INT      = 6'd5;
    localparam logic [5:0] KIND_FLOAT    = 6'd6;
    localparam logic [5:0] KIND_STRING   = 6'd7;
    localparam logic [5:0] KIND_CHAR     = 6'd8;
    localparam logic [5:0] KIND_ARROW    = 6'd9;
    localparam logic [5:0] KIND_EQ       = 6'd10;
    localparam logic [5:0] KIND_NE       = 6'd11;
    localparam logic [5:0] KIND_LE       = 6'd12;
    localparam logic [5:0] KIND_GE       = 6'd13;
    localparam logic [5:0] KIND_LAND     = 6'd14;
    localparam logic [5:0] KIND_LOR      = 6'd15;
    localparam logic [5:0] KIND_INC      = 6'd16;
    localparam logic [5:0] KIND_DEC      = 6'd17;
    localparam logic [5:0] KIND_OP1_BASE = 6'd18;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_OPEN_BLOCK = 3'd1;
    localparam logic [2:0] ERR_LIT_NL     = 3'd2;
    localparam logic [2:0] ERR_LIT_END    = 3'd3;
    localparam logic [2:0] ERR_BAD_CHAR   = 3'd4;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [2:0]  error_code;
        logic [19:0] start_offset;
        logic [19:0] token_length;
        logic [15:0] start_line;
        logic [15:0] start_col;
        logic        is_last;
    } t_out_item;

    typedef struct packed {
        logic       digit;
        logic       alpha;
        logic       space;
        logic [5:0] op1;
    } t_cls;

    typedef struct packed {
        t_in_item item;
        t_cls     cls;
    } t_fq_entry;

    function automatic logic [5:0] op1_kind(input logic [7:0] c);
        logic [4:0] idx;
        logic       hit;
        idx = 5'd0;
        hit = 1'b1;
        case (c)
            "+": idx = 5'd0;
            "-": idx = 5'd1;
            "*": idx = 5'd2;
            "/": idx = 5'd3;
            "%": idx = 5'd4;
            "!": idx = 5'd5;
            "&": idx = 5'd6;
            "|": idx = 5'd7;
            "=": idx = 5'd8;
            "<": idx = 5'd9;
            ">": idx = 5'd10;
            "(": idx = 5'd11;
            ")": idx = 5'd12;
            "{": idx = 5'd13;
            "}": idx = 5'd14;
            "[": idx = 5'd15;
            "]": idx = 5'd16;
            ",": idx = 5'd17;
            ".": idx = 5'd18;
            ":": idx = 5'd19;
            default: hit = 1'b0;
        endcase
        return hit ? (KIND_OP1_BASE + 6'(idx)) : KIND_EOF;
    endfunction

    function automatic logic [5:0] op2_kind(input logic [7:0] h, input logic [7:0] la);
        logic [5:0] k;
        case ({h, la})
            "->":    k = KIND_ARROW;
            "==":    k = KIND_EQ;
            "!=":    k = KIND_NE;
            "<=":    k = KIND_LE;
            ">=":    k = KIND_GE;
            "&&":    k = KIND_LAND;
            "||":    k = KIND_LOR;
            "++":    k = KIND_INC;
            "--":    k = KIND_DEC;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r.digit = (c >= "0") && (c <= "9");
        r.alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
        r.space = (c == " ") || (c == 8'h09) || (c == CH_CR) || (c == 8'h0B) || (c == 8'h0C);
        r.op1   = op1_kind(c);
        return r;
    endfunction

endpackage

[rtl/stt_front.sv]
// Front end: classifies incoming bytes and queues them for the scanner.
module stt_front
    import stt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_fq_entry o_head
);
    localparam int AW = $clog2(FQ_DEPTH);

    t_fq_entry           r_mem [FQ_DEPTH];
    logic [AW-1:0]       r_wp, r_rp;
    logic [AW:0]         r_cnt;
    logic                w_push, w_pop;

    assign full    = (r_cnt == (AW+1)'(FQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = push && !full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{item: i_item, cls: classify(i_item.char_code)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

endmodule

[rtl/stt_back.sv]
// Back end: scanner state machine that turns byte pairs into tokens.
module stt_back
    import stt_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = DEF_MAX_TEXT_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_keep,
    input  logic      i_q_empty,
    input  t_fq_entry i_head,
    output logic      o_q_pop,
    input  logic      i_res_full,
    output logic      o_res_push,
    output t_out_item o_res
);
    localparam logic [19:0] OFS_CAP =
        ((MAX_TEXT_BYTES - 1) < 20'hFFFFF) ? 20'(MAX_TEXT_BYTES - 1) : 20'hFFFFF;

    typedef enum logic [12:0] {
        M_IDLE   = 13'b0000000000001,
        M_CRLF   = 13'b0000000000010,
        M_LINE   = 13'b0000000000100,
        M_BOPEN  = 13'b0000000001000,
        M_BBODY  = 13'b0000000010000,
        M_BCLOSE = 13'b0000000100000,
        M_IDENT  = 13'b0000001000000,
        M_INT    = 13'b0000010000000,
        M_DOT    = 13'b0000100000000,
        M_FRAC   = 13'b0001000000000,
        M_STR    = 13'b0010000000000,
        M_CHR    = 13'b0100000000000,
        M_OP2    = 13'b1000000000000
    } t_mode;

    typedef enum logic [2:0] {
        PH_PAIR = 3'b001,
        PH_LAST = 3'b010,
        PH_EOF  = 3'b100
    } t_phase;

    t_phase      r_phase;
    t_mode       r_mode, n_mode;
    logic [7:0]  r_held;
    t_cls        r_hcls;
    logic        r_hv;
    logic [19:0] r_ofs, r_open_ofs;
    logic [15:0] r_line, r_col, r_open_line, r_open_col;
    logic        r_esc, n_esc;
    logic        r_hold, n_hold;
    logic [5:0]  r_op, n_op;

    logic        w_step, w_proc;
    logic [7:0]  h, la;
    t_cls        hc, lac;
    logic        lav;
    logic [19:0] w_nofs, w_sofs;
    logic [15:0] w_nline, w_ncol, w_sline, w_scol;
    logic        ev_emit, ev_fail;
    logic [5:0]  ev_kind, w_lkind, w_op2;
    logic [2:0]  ev_err;
    logic [7:0]  w_quote;

    assign w_step  = !i_q_empty && !i_res_full;
    assign w_proc  = w_step && ((r_phase == PH_PAIR && r_hv) || r_phase == PH_LAST);
    assign o_q_pop = w_step && ((r_phase == PH_PAIR && !i_head.item.end_of_text)
                                || r_phase == PH_EOF);

    always_comb begin
        if (r_phase == PH_PAIR) begin
            h   = r_held;
            hc  = r_hcls;
            la  = i_head.item.char_code;
            lac = i_head.cls;
            lav = 1'b1;
        end else begin
            h   = i_head.item.char_code;
            hc  = i_head.cls;
            la  = '0;
            lac = '0;
            lav = 1'b0;
        end
    end

    assign w_nofs  = (r_ofs < OFS_CAP) ? r_ofs + 20'd1 : r_ofs;
    assign w_nline = (h == CH_LF && r_line != 16'hFFFF) ? r_line + 16'd1 : r_line;
    assign w_ncol  = (h == CH_LF) ? 16'd1 : ((r_col != 16'hFFFF) ? r_col + 16'd1 : r_col);
    assign w_sofs  = (r_mode == M_IDLE) ? r_ofs  : r_open_ofs;
    assign w_sline = (r_mode == M_IDLE) ? r_line : r_open_line;
    assign w_scol  = (r_mode == M_IDLE) ? r_col  : r_open_col;
    assign w_lkind = (r_mode == M_STR) ? KIND_STRING : KIND_CHAR;
    assign w_quote = (r_mode == M_STR) ? CH_DQUOTE : CH_SQUOTE;
    assign w_op2   = lav ? op2_kind(h, la) : KIND_EOF;

    always_comb begin
        n_mode  = r_mode;
        n_esc   = r_esc;
        n_op    = r_op;
        n_hold  = r_hold;
        ev_emit = 1'b0;
        ev_fail = 1'b0;
        ev_kind = KIND_EOF;
        ev_err  = ERR_NONE;
        unique case (r_mode)
            M_IDLE: begin
                if (h == CH_LF) begin
                    ev_emit = 1'b1;
                    ev_kind = KIND_NEWLINE;
                end else if (h == CH_CR && lav && la == CH_LF) begin
                    n_mode = M_CRLF;
                end else if (hc.space) begin
                    n_mode = M_IDLE;
                end else if (h == CH_HASH) begin
                    if (lav && la == CH_STAR) begin
                        n_mode = M_BOPEN;
                    end else if (!lav || la == CH_LF) begin
                        ev_emit = i_keep;
                        ev_kind = KIND_LINE;
                    end else begin
                        n_mode = M_LINE;
                    end
                end else if (hc.alpha) begin
                    if (lav && (lac.alpha || lac.digit)) begin
                        n_mode = M_IDENT;
                    end else begin
                        ev_emit = 1'b1;
                        ev_kind = KIND_IDENT;
                    end
                end else if (hc.digit) begin
                    if (lav && lac.digit) begin
                        n_mode = M_INT;
                    end else if (lav && la == CH_DOT) begin
                        n_mode = M_DOT;
                    end else begin
                        ev_emit = 1'b1;
                        ev_kind = KIND_INT;
                    end
                end else if (h == CH_DOT && lav && lac.digit) begin
                    n_mode = M_FRAC;
                end else if (h == CH_DQUOTE || h == CH_SQUOTE) begin
                    n_esc  = 1'b0;
                    n_mode = (h == CH_DQUOTE) ? M_STR : M_CHR;
                    if (!lav) begin
                        ev_fail = 1'b1;
                        ev_kind = (h == CH_DQUOTE) ? KIND_STRING : KIND_CHAR;
                        ev_err  = ERR_LIT_END;
                    end
                end else if (w_op2 != KIND_EOF) begin
                    n_op   = w_op2;
                    n_mode = M_OP2;
                end else if (hc.op1 != KIND_EOF) begin
                    ev_emit = 1'b1;
                    ev_kind = hc.op1;
                end else begin
                    ev_fail = 1'b1;
                    ev_kind = KIND_EOF;
                    ev_err  = ERR_BAD_CHAR;
                end
            end
            M_CRLF: begin
                ev_emit = 1'b1;
                ev_kind = KIND_NEWLINE;
            end
            M_LINE: begin
                if (!lav || la == CH_LF) begin
                    n_mode  = M_IDLE;
                    ev_emit = i_keep;
                    ev_kind = KIND_LINE;
                end
            end
            M_BOPEN: begin
                n_mode = M_BBODY;
                if (!lav) begin
                    ev_fail = 1'b1;
                    ev_kind = KIND_BLOCK;
                    ev_err  = ERR_OPEN_BLOCK;
                end
            end
            M_BBODY: begin
                if (h == CH_STAR && lav && la == CH_HASH) begin
                    n_mode = M_BCLOSE;
                end else if (!lav) begin
                    ev_fail = 1'b1;
                    ev_kind = KIND_BLOCK;
                    ev_err  = ERR_OPEN_BLOCK;
                end
            end
            M_BCLOSE: begin
                n_mode  = M_IDLE;
                ev_emit = i_keep;
                ev_kind = KIND_BLOCK;
            end
            M_IDENT: begin
                if (!(lav && (lac.alpha || lac.digit))) begin
                    ev_emit = 1'b1;
                    ev_kind = KIND_IDENT;
                end
            end
            M_INT: begin
                if (lav && lac.digit) begin
                    n_mode = M_INT;
                end else if (lav && la == CH_DOT) begin
                    n_mode = M_DOT;
                end else begin
                    ev_emit = 1'b1;
                    ev_kind = KIND_INT;
                end
            end
            M_DOT, M_FRAC: begin
                if (lav && lac.digit) begin
                    n_mode = M_FRAC;
                end else begin
                    ev_emit = 1'b1;
                    ev_kind = KIND_FLOAT;
                end
            end
            M_STR, M_CHR: begin
                ev_kind = w_lkind;
                if (!r_esc && h == w_quote) begin
                    ev_emit = 1'b1;
                end else if (!r_esc && h != CH_BSLASH && h == CH_LF) begin
                    ev_fail = 1'b1;
                    ev_err  = ERR_LIT_NL;
                end else begin
                    n_esc = !r_esc && (h == CH_BSLASH);
                    if (!lav) begin
                        ev_fail = 1'b1;
                        ev_err  = ERR_LIT_END;
                    end
                end
            end
            M_OP2: begin
                ev_emit = 1'b1;
                ev_kind = r_op;
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase
        if (ev_fail) begin
            ev_emit = 1'b1;
            n_hold  = 1'b1;
            n_mode  = M_IDLE;
        end else if (ev_emit) begin
            n_mode = M_IDLE;
        end
    end

    always_comb begin
        if (r_phase == PH_EOF) begin
            o_res_push         = w_step && !r_hold;
            o_res.token_kind   = KIND_EOF;
            o_res.error_code   = ERR_NONE;
            o_res.start_offset = r_ofs;
            o_res.token_length = '0;
            o_res.start_line   = r_line;
            o_res.start_col    = r_col;
            o_res.is_last      = 1'b1;
        end else begin
            o_res_push         = w_proc && !r_hold && ev_emit;
            o_res.token_kind   = ev_kind;
            o_res.error_code   = ev_err;
            o_res.start_offset = w_sofs;
            o_res.token_length = w_nofs - w_sofs;
            o_res.start_line   = w_sline;
            o_res.start_col    = w_scol;
            o_res.is_last      = ev_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_step && r_phase == PH_EOF)) begin
            r_mode      <= M_IDLE;
            r_hv        <= 1'b0;
            r_held      <= '0;
            r_hcls      <= '0;
            r_ofs       <= '0;
            r_line      <= 16'd1;
            r_col       <= 16'd1;
            r_open_ofs  <= '0;
            r_open_line <= 16'd1;
            r_open_col  <= 16'd1;
            r_esc       <= 1'b0;
            r_hold      <= 1'b0;
            r_op        <= KIND_EOF;
        end else begin
            if (w_proc && !r_hold) begin
                r_mode <= n_mode;
                r_esc  <= n_esc;
                r_op   <= n_op;
                r_hold <= n_hold;
                r_ofs  <= w_nofs;
                r_line <= w_nline;
                r_col  <= w_ncol;
                if (r_mode == M_IDLE) begin
                    r_open_ofs  <= r_ofs;
                    r_open_line <= r_line;
                    r_open_col  <= r_col;
                end
            end
            if (w_step && r_phase == PH_PAIR) begin
                r_held <= i_head.item.char_code;
                r_hcls <= i_head.cls;
                r_hv   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PAIR;
        end else if (w_step) begin
            unique case (r_phase)
                PH_PAIR: r_phase <= i_head.item.end_of_text ? PH_LAST : PH_PAIR;
                PH_LAST: r_phase <= PH_EOF;
                PH_EOF:  r_phase <= PH_PAIR;
                default: r_phase <= PH_PAIR;
            endcase
        end
    end

endmodule

[rtl/stt_outq.sv]
// Result queue between the scanner and the consumer.
module stt_outq
    import stt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_res,
    output logic      o_full,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_result
);
    localparam int AW = $clog2(OQ_DEPTH);

    t_out_item     r_mem [OQ_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_full   = (r_cnt == (AW+1)'(OQ_DEPTH));
    assign empty    = (r_cnt == '0);
    assign w_push   = i_push && !o_full;
    assign w_pop    = pop && !empty;
    assign o_result = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

endmodule

[rtl/source_text_tokenizer_core.sv]
// Top level of the source text tokenizer: byte queue, scanner, result queue.
//
//  channel   direction  handshake             payload
//  input     in         push / full           i_item   (t_in_item)
//  result    out        empty / pop           o_result (t_out_item)
//  config    in         i_cfg_we              i_cfg_wdata (keep_comments)
//
//  One byte per scanner cycle while the byte queue holds data and the result
//  queue is not full; an end_of_text byte goes through these phases in order:
//  pair with the byte before, last byte alone, EOF and text reset.
//  A full result queue stalls the scanner; the byte queue then absorbs up to
//  four transactions before full rises.
//  Synchronous active-low reset clears both queues and all text state.
module source_text_tokenizer_core
    import stt_pkg::*;
#(
    parameter int MAX_TEXT_BYTES = DEF_MAX_TEXT_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    output logic      full,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);
    logic      r_keep;
    logic      w_q_empty, w_q_pop, w_res_full, w_res_push;
    t_fq_entry w_head;
    t_out_item w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b0;
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_wdata;
        end
    end

    stt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_item  (i_item),
        .full    (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_head  (w_head)
    );

    stt_back #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_keep     (r_keep),
        .i_q_empty  (w_q_empty),
        .i_head     (w_head),
        .o_q_pop    (w_q_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    stt_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_push),
        .i_res    (w_res),
        .o_full   (w_res_full),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_res_full))
        else $error("result written into full queue");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("byte queue popped while empty");

    a_last_is_eof_or_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_push && w_res.is_last) |->
            (w_res.error_code != ERR_NONE || w_res.token_kind == KIND_EOF))
        else $error("last result is neither EOF nor error");

endmodule

[tb/tb_token_checker.sv]
// Token checker: predicts the tokens of each source text and compares them with the result queue.
module tb_token_checker
    import stt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    input  t_in_item  i_item,
    input  logic      full,
    input  logic      empty,
    input  logic      pop,
    input  t_out_item o_result,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_token_count
);

    typedef enum logic [3:0] {
        SM_IDLE, SM_CRLF, SM_LINE, SM_BOPEN, SM_BBODY, SM_BCLOSE, SM_IDENT,
        SM_INT, SM_DOT, SM_FRAC, SM_STR, SM_CHR, SM_OP2
    } t_scan_mode;

    localparam logic [19:0] OFS_CAP = 20'hFFFFF;

    t_out_item  token_queue[$];
    logic       keep_cmt;
    t_scan_mode mode;
    logic [7:0] held;
    logic       held_ok;
    logic [19:0] ofs, tok_ofs;
    logic [15:0] line_no, col_no, tok_line, tok_col;
    logic       esc, err_hold;
    logic [5:0] pend_op;
    int         fails;
    int         tokens;

    assign o_fail_count  = fails;
    assign o_pending     = token_queue.size();
    assign o_token_count = tokens;

    function automatic logic is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alp(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return c == " " || c == 8'h09 || c == CH_CR || c == 8'h0B || c == 8'h0C;
    endfunction

    function automatic logic [5:0] single_op(logic [7:0] c);
        case (c)
            "+": return KIND_OP1_BASE + 6'd0;
            "-": return KIND_OP1_BASE + 6'd1;
            "*": return KIND_OP1_BASE + 6'd2;
            "/": return KIND_OP1_BASE + 6'd3;
            "%": return KIND_OP1_BASE + 6'd4;
            "!": return KIND_OP1_BASE + 6'd5;
            "&": return KIND_OP1_BASE + 6'd6;
            "|": return KIND_OP1_BASE + 6'd7;
            "=": return KIND_OP1_BASE + 6'd8;
            "<": return KIND_OP1_BASE + 6'd9;
            ">": return KIND_OP1_BASE + 6'd10;
            "(": return KIND_OP1_BASE + 6'd11;
            ")": return KIND_OP1_BASE + 6'd12;
            "{": return KIND_OP1_BASE + 6'd13;
            "}": return KIND_OP1_BASE + 6'd14;
            "[": return KIND_OP1_BASE + 6'd15;
            "]": return KIND_OP1_BASE + 6'd16;
            ",": return KIND_OP1_BASE + 6'd17;
            ".": return KIND_OP1_BASE + 6'd18;
            ":": return KIND_OP1_BASE + 6'd19;
            default: return KIND_EOF;
        endcase
    endfunction

    function automatic logic [5:0] pair_op(logic [7:0] h, logic [7:0] la);
        case ({h, la})
            "->": return KIND_ARROW;
            "==": return KIND_EQ;
            "!=": return KIND_NE;
            "<=": return KIND_LE;
            ">=": return KIND_GE;
            "&&": return KIND_LAND;
            "||": return KIND_LOR;
            "++": return KIND_INC;
            "--": return KIND_DEC;
            default: return KIND_EOF;
        endcase
    endfunction

    task automatic clear_text();
        mode = SM_IDLE; held = '0; held_ok = 0; ofs = '0;
        line_no = 16'd1; col_no = 16'd1; tok_ofs = '0; tok_line = 16'd1; tok_col = 16'd1;
        esc = 0; err_hold = 0; pend_op = KIND_EOF;
    endtask

    task automatic add_token(logic [5:0] k, logic [2:0] e, logic [19:0] o, logic [19:0] n,
                             logic [15:0] l, logic [15:0] c, logic last);
        t_out_item t;
        t.token_kind = k; t.error_code = e; t.start_offset = o; t.token_length = n;
        t.start_line = l; t.start_col = c; t.is_last = last;
        token_queue.insert(token_queue.size(), t);
    endtask

    task automatic step_pos(logic [7:0] c);
        if (c == CH_LF) begin
            if (line_no != 16'hFFFF) line_no++;
            col_no = 16'd1;
        end else if (col_no != 16'hFFFF) begin
            col_no++;
        end
        if (ofs != OFS_CAP) ofs++;
    endtask

    task automatic close_token(logic [5:0] k);
        add_token(k, ERR_NONE, tok_ofs, ofs - tok_ofs, tok_line, tok_col, 1'b0);
        mode = SM_IDLE;
    endtask

    task automatic abort_text(logic [5:0] k, logic [2:0] e);
        add_token(k, e, tok_ofs, ofs - tok_ofs, tok_line, tok_col, 1'b1);
        err_hold = 1; mode = SM_IDLE;
    endtask

    task automatic open_token(logic [7:0] h, logic [7:0] la, logic lav);
        logic [5:0] k2;
        tok_ofs = ofs; tok_line = line_no; tok_col = col_no;
        k2 = lav ? pair_op(h, la) : KIND_EOF;
        if (h == CH_LF) begin
            step_pos(h); close_token(KIND_NEWLINE);
        end else if (h == CH_CR && lav && la == CH_LF) begin
            step_pos(h); mode = SM_CRLF;
        end else if (is_ws(h)) begin
            step_pos(h);
        end else if (h == CH_HASH) begin
            step_pos(h);
            if (lav && la == CH_STAR) mode = SM_BOPEN;
            else if (!lav || la == CH_LF) begin
                if (keep_cmt) close_token(KIND_LINE);
            end else mode = SM_LINE;
        end else if (is_alp(h)) begin
            step_pos(h);
            if (lav && (is_alp(la) || is_dig(la))) mode = SM_IDENT;
            else close_token(KIND_IDENT);
        end else if (is_dig(h)) begin
            step_pos(h);
            if (lav && is_dig(la)) mode = SM_INT;
            else if (lav && la == CH_DOT) mode = SM_DOT;
            else close_token(KIND_INT);
        end else if (h == CH_DOT && lav && is_dig(la)) begin
            step_pos(h); mode = SM_FRAC;
        end else if (h == CH_DQUOTE || h == CH_SQUOTE) begin
            step_pos(h); esc = 0;
            mode = (h == CH_DQUOTE) ? SM_STR : SM_CHR;
            if (!lav) abort_text(h == CH_DQUOTE ? KIND_STRING : KIND_CHAR, ERR_LIT_END);
        end else begin
            step_pos(h);
            if (k2 != KIND_EOF) begin
                pend_op = k2; mode = SM_OP2;
            end else if (single_op(h) != KIND_EOF) begin
                close_token(single_op(h));
            end else begin
                abort_text(KIND_EOF, ERR_BAD_CHAR);
            end
        end
    endtask

    task automatic scan_byte(logic [7:0] h, logic [7:0] la, logic lav);
        logic [5:0] k;
        if (err_hold) return;
        case (mode)
            SM_CRLF: begin
                step_pos(h); close_token(KIND_NEWLINE);
            end
            SM_LINE: begin
                step_pos(h);
                if (!lav || la == CH_LF) begin
                    if (keep_cmt) close_token(KIND_LINE); else mode = SM_IDLE;
                end
            end
            SM_BOPEN: begin
                step_pos(h); mode = SM_BBODY;
                if (!lav) abort_text(KIND_BLOCK, ERR_OPEN_BLOCK);
            end
            SM_BBODY: begin
                step_pos(h);
                if (h == CH_STAR && lav && la == CH_HASH) mode = SM_BCLOSE;
                else if (!lav) abort_text(KIND_BLOCK, ERR_OPEN_BLOCK);
            end
            SM_BCLOSE: begin
                step_pos(h);
                if (keep_cmt) close_token(KIND_BLOCK); else mode = SM_IDLE;
            end
            SM_IDENT: begin
                step_pos(h);
                if (!(lav && (is_alp(la) || is_dig(la)))) close_token(KIND_IDENT);
            end
            SM_INT: begin
                step_pos(h);
                if (lav && is_dig(la)) begin
                end else if (lav && la == CH_DOT) mode = SM_DOT;
                else close_token(KIND_INT);
            end
            SM_DOT, SM_FRAC: begin
                step_pos(h);
                if (lav && is_dig(la)) mode = SM_FRAC; else close_token(KIND_FLOAT);
            end
            SM_STR, SM_CHR: begin
                k = (mode == SM_STR) ? KIND_STRING : KIND_CHAR;
                step_pos(h);
                if (esc) esc = 0;
                else if (h == CH_BSLASH) esc = 1;
                else if (h == ((k == KIND_STRING) ? CH_DQUOTE : CH_SQUOTE)) begin
                    close_token(k); return;
                end else if (h == CH_LF) begin
                    abort_text(k, ERR_LIT_NL); return;
                end
                if (!lav) abort_text(k, ERR_LIT_END);
            end
            SM_OP2: begin
                step_pos(h); close_token(pend_op);
            end
            default: begin
                mode = SM_IDLE; open_token(h, la, lav);
            end
        endcase
    endtask

    task automatic take_byte(t_in_item it);
        if (held_ok) scan_byte(held, it.char_code, 1'b1);
        held = it.char_code; held_ok = 1;
        if (it.end_of_text) begin
            scan_byte(held, 8'h00, 1'b0);
            if (!err_hold) add_token(KIND_EOF, ERR_NONE, ofs, '0, line_no, col_no, 1'b1);
            clear_text();
        end
    endtask

    task automatic match_token(t_out_item got);
        t_out_item exp_t;
        if (token_queue.size() == 0) begin
            $error("token with nothing expected: kind %0d", got.token_kind);
            fails++;
            return;
        end
        exp_t = token_queue.pop_front();
        tokens++;
        if (got.token_kind !== exp_t.token_kind) begin
            $error("token_kind exp %0d got %0d", exp_t.token_kind, got.token_kind); fails++;
        end
        if (got.error_code !== exp_t.error_code) begin
            $error("error_code exp %0d got %0d", exp_t.error_code, got.error_code); fails++;
        end
        if (got.start_offset !== exp_t.start_offset) begin
            $error("start_offset exp %0d got %0d", exp_t.start_offset, got.start_offset);
            fails++;
        end
        if (got.token_length !== exp_t.token_length) begin
            $error("token_length exp %0d got %0d", exp_t.token_length, got.token_length);
            fails++;
        end
        if (got.start_line !== exp_t.start_line) begin
            $error("start_line exp %0d got %0d", exp_t.start_line, got.start_line); fails++;
        end
        if (got.start_col !== exp_t.start_col) begin
            $error("start_col exp %0d got %0d", exp_t.start_col, got.start_col); fails++;
        end
        if (got.is_last !== exp_t.is_last) begin
            $error("is_last exp %0d got %0d", exp_t.is_last, got.is_last); fails++;
        end
    endtask

    initial begin
        fails = 0; tokens = 0; keep_cmt = 0;
        clear_text();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            keep_cmt = 0;
            clear_text();
            token_queue.delete();
        end else begin
            if (!empty && pop) match_token(o_result);
            if (push && !full) take_byte(i_item);
            if (i_cfg_we) keep_cmt = i_cfg_wdata;
        end
    end

endmodule

[tb/tb_top.sv]
// Testbench top: drives source texts into the tokenizer and reports the verdict.
module tb_top;
    import stt_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    t_in_item  i_item;
    logic      full;
    logic      empty;
    logic      pop;
    t_out_item o_result;
    logic      i_cfg_we;
    logic      i_cfg_wdata;
    int        fail_count;
    int        pending;
    int        token_count;

    int        send_idle_pct;
    int        recv_stall_pct;
    int        bytes_sent;
    int        texts_sent;
    int        quiet_cycles;
    byte       text_buf[$];

    source_text_tokenizer_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    tb_token_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .i_item(i_item), .full(full),
        .empty(empty), .pop(pop), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .o_fail_count(fail_count), .o_pending(pending),
        .o_token_count(token_count)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_text();
        int k;
        k = 0;
        while (k < text_buf.size()) begin
            while ($urandom_range(99) < send_idle_pct) begin
                push <= 0;
                @(negedge i_clk);
            end
            push <= 1;
            i_item.char_code <= text_buf[k];
            i_item.end_of_text <= (k == text_buf.size() - 1);
            @(posedge i_clk);
            if (!full) k++;
            @(negedge i_clk);
        end
        push <= 0;
        bytes_sent += text_buf.size();
        texts_sent++;
        text_buf.delete();
    endtask

    task automatic add_byte(byte b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic put_str(string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k]);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_keep(logic v);
        drain();
        i_cfg_we <= 1; i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_fragment();
        int sel;
        int n;
        sel = $urandom_range(15);
        n = $urandom_range(1, 5);
        case (sel)
            0: put_str("abc_9");
            1: repeat (n) add_byte(byte'("0" + $urandom_range(9)));
            2: if ($urandom_range(1)) put_str("12.5"); else put_str(".75");
            3: put_str("\"a\\\"b\"");
            4: put_str("'\\n'");
            5: put_str("#* x *#");
            6: put_str("# note\r");
            7: add_byte(8'h0A);
            8: put_str("\r\n");
            9: put_str(" \t");
            10: put_str($urandom_range(1) ? "->" : "&&");
            11: put_str("+-*/%!&|=<>(){}[],.:");
            12: put_str("== != <= >= || ++ --");
            13: add_byte(byte'($urandom_range(255)));
            14: add_byte(byte'("a" + $urandom_range(25)));
            default: put_str(" x1 ");
        endcase
    endtask

    initial begin
        i_rst_n = 0; push = 0; i_item = '0; pop = 0; i_cfg_we = 0; i_cfg_wdata = 0;
        send_idle_pct = 0; recv_stall_pct = 0; bytes_sent = 0; texts_sent = 0;
        quiet_cycles = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        put_str("x\n"); send_text();
        put_str("a_Z9 0 42 1. .5 3.25 \"s\\\"q\" 'c'\r\n"); send_text();
        put_str("-> == != <= >= && || ++ --+-*/%!&|=<>(){}[],.:"); send_text();
        put_str("#c\r\n#*a*b*# #*#"); send_text();
        set_keep(1);
        put_str("#line\n#*blk*#\n#"); send_text();
        put_str("#*#*"); send_text();
        put_str("\"ab\n"); send_text();
        put_str("'a"); send_text();
        put_str("\""); send_text();
        add_byte(8'h00); put_str(" q"); send_text();
        add_byte(8'hFF); send_text();
        add_byte(8'h80); put_str("7"); send_text();
        put_str("@"); send_text();
        set_keep(0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            set_keep(ph[0]);
            for (int t = 0; t < 4; t++) begin
                repeat ($urandom_range(2, 5)) random_fragment();
                if ($urandom_range(3) == 0) add_byte(byte'($urandom_range(255)));
                send_text();
                if (t == 2) while (pending != 0) @(negedge i_clk);
            end
        end

        drain();
        $display("Covered %0d texts, %0d bytes, %0d tokens checked", texts_sent, bytes_sent,
                 token_count);
        $display("with comment keep on and off, all stall mixes and every error kind.");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[files.f]
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_back.sv
rtl/stt_outq.sv
rtl/source_text_tokenizer_core.sv
tb/tb_token_checker.sv
tb/tb_top.sv
